### sv/dklc_pkg.sv
// ============================================================================
// dklc_pkg
// Shared types and constants for the draw key lru cache: request and result
// payloads, and the command and status groups between controller and datapath.
// ============================================================================
package dklc_pkg;

    // default table depth
    localparam int CACHE_ENTRIES_DEF = 128;
    // width of the reported slot field
    localparam int SLOT_W = 7;
    // width of the use stamps and the use counter
    localparam int STAMP_W = 32;
    // first vertex value that marks an indexed draw
    localparam logic signed [31:0] INDEXED_FIRST = -32'sd1;

    // one draw request key, also the stored key form
    typedef struct packed {
        logic signed [31:0] first_vertex;
        logic [30:0]        draw_count;
        logic [30:0]        vertex_count;
        logic [63:0]        index_addr;
        logic               index_is_short;
        logic [63:0]        position_addr;
        logic [63:0]        normal_addr;
        logic [63:0]        color_addr;
        logic [63:0]        texcoord0_addr;
        logic [63:0]        texcoord1_addr;
        logic [4:0]         enable_mask;
        logic [1:0]         color_format;
    } t_draw_req;

    // one lookup result
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted_valid;
    } t_draw_res;

    // controller to datapath commands
    typedef struct packed {
        logic key_load;
        logic scan_clear;
        logic scan_issue;
        logic commit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
    } t_dp_stat;

    // array draws ignore the index fields: they are kept as zero
    function automatic t_draw_req norm_key(input t_draw_req req);
        t_draw_req key;
        key = req;
        if (req.first_vertex != INDEXED_FIRST) begin
            key.vertex_count   = '0;
            key.index_addr     = '0;
            key.index_is_short = 1'b0;
        end
        return key;
    endfunction

endpackage

### sv/dklc_datapath.sv
// ============================================================================
// dklc_datapath
// Key and stamp memories, valid bits, scan address, one-entry-per-cycle
// compare stage with hit / first-invalid / oldest-stamp tracking, and the
// result register.
// ============================================================================
module dklc_datapath #(
    parameter int CACHE_ENTRIES = dklc_pkg::CACHE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(CACHE_ENTRIES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dklc_pkg::t_draw_req i_req,
    input  dklc_pkg::t_dp_cmd   i_cmd,
    output dklc_pkg::t_dp_stat  o_stat,
    output dklc_pkg::t_draw_res o_res
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    // storage
    dklc_pkg::t_draw_req          key_mem   [CACHE_ENTRIES];
    logic [dklc_pkg::STAMP_W-1:0] stamp_mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0]     r_valid;
    logic [dklc_pkg::STAMP_W-1:0] r_counter;
    logic [dklc_pkg::STAMP_W-1:0] n_counter;

    // current key and scan address
    dklc_pkg::t_draw_req r_key;
    logic [IDX_W-1:0]    r_addr;

    // read stage
    dklc_pkg::t_draw_req          r_rd_key;
    logic [dklc_pkg::STAMP_W-1:0] r_rd_stamp;
    logic                         r_rd_valid;
    logic [IDX_W-1:0]             r_rd_idx;
    logic                         r_cmp_vld;

    // trackers
    logic                         r_hit_found;
    logic [IDX_W-1:0]             r_hit_idx;
    logic                         r_inv_found;
    logic [IDX_W-1:0]             r_inv_idx;
    logic                         r_min_set;
    logic [IDX_W-1:0]             r_min_idx;
    logic [dklc_pkg::STAMP_W-1:0] r_min_stamp;

    // commit selection
    logic [IDX_W-1:0]                 pick;
    logic [IDX_W+dklc_pkg::SLOT_W-1:0] pick_ext;
    logic                             match;
    dklc_pkg::t_draw_res              r_res;

    assign n_counter = r_counter + dklc_pkg::STAMP_W'(1);
    assign match     = r_rd_valid && (r_rd_key == r_key);
    assign pick      = r_hit_found ? r_hit_idx : (r_inv_found ? r_inv_idx : r_min_idx);
    assign pick_ext  = {{dklc_pkg::SLOT_W{1'b0}}, pick};

    assign o_stat.scan_last = (r_addr == LAST_IDX);
    assign o_res            = r_res;

    // key capture and scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            r_key <= dklc_pkg::norm_key(i_req);
        end
        if (i_cmd.scan_clear) begin
            r_addr <= '0;
        end else if (i_cmd.scan_issue) begin
            r_addr <= r_addr + IDX_W'(1);
        end
    end

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_issue) begin
            r_rd_key   <= key_mem[r_addr];
            r_rd_stamp <= stamp_mem[r_addr];
            r_rd_valid <= r_valid[r_addr];
            r_rd_idx   <= r_addr;
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            stamp_mem[pick] <= n_counter;
            if (!r_hit_found) begin
                key_mem[pick] <= r_key;
            end
        end
    end

    // valid bits, use counter and compare tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_counter   <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit_found <= 1'b0;
            r_inv_found <= 1'b0;
            r_min_set   <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_issue;
            if (i_cmd.commit) begin
                r_counter <= n_counter;
                if (!r_hit_found) begin
                    r_valid[pick] <= 1'b1;
                end
            end
            if (i_cmd.scan_clear) begin
                r_hit_found <= 1'b0;
                r_inv_found <= 1'b0;
                r_min_set   <= 1'b0;
            end else if (r_cmp_vld) begin
                // first matching valid entry
                if (match && !r_hit_found) begin
                    r_hit_found <= 1'b1;
                    r_hit_idx   <= r_rd_idx;
                end
                // first free entry
                if (!r_rd_valid && !r_inv_found) begin
                    r_inv_found <= 1'b1;
                    r_inv_idx   <= r_rd_idx;
                end
                // oldest valid entry, earliest slot on ties
                if (r_rd_valid && (!r_min_set || (r_rd_stamp < r_min_stamp))) begin
                    r_min_set   <= 1'b1;
                    r_min_idx   <= r_rd_idx;
                    r_min_stamp <= r_rd_stamp;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res.hit           <= r_hit_found;
            r_res.slot          <= pick_ext[dklc_pkg::SLOT_W-1:0];
            r_res.evicted_valid <= !r_hit_found && !r_inv_found;
        end
    end

endmodule

### sv/dklc_ctrl.sv
// ============================================================================
// dklc_ctrl
// Sequencer for one lookup: accept, scan all entries, drain the compare
// stage, commit once the result register is free.
// ============================================================================
module dklc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  dklc_pkg::t_dp_stat i_stat,
    output dklc_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       out_free;
    logic       in_acc;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd.key_load   = 1'b0;
        o_cmd.scan_clear = 1'b0;
        o_cmd.scan_issue = 1'b0;
        o_cmd.commit     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    o_cmd.key_load   = 1'b1;
                    o_cmd.scan_clear = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### sv/draw_key_lru_cache_unit.sv
// ============================================================================
// draw_key_lru_cache_unit
// Fully associative draw key cache with timestamp lru replacement.
// ============================================================================
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------
//  request   | in        | i_in_valid / o_in_ready   | i_in_data  t_draw_req
//  result    | out       | o_out_valid / i_out_ready | o_out_data t_draw_res
//
//  one transaction scans all CACHE_ENTRIES entries, then drains and commits: the
//  scan reads one table entry per cycle through the single memory read port
//  the table valid bits clear at reset, no clearing pass needed
//  a new request is taken while the previous result waits in its register;
//  a stalled result only holds the commit of the following request
// ============================================================================
module draw_key_lru_cache_unit #(
    parameter int CACHE_ENTRIES = dklc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dklc_pkg::t_draw_req i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dklc_pkg::t_draw_res o_out_data
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);

    dklc_pkg::t_dp_cmd  cmd;
    dklc_pkg::t_dp_stat stat;

    // sequencer
    dklc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // table and compare logic
    dklc_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_out_data)
    );

endmodule

### sv/dklc_checker.sv
// ============================================================================
// dklc_checker
// Port level checks on the draw key cache, attached to the top level.
// ============================================================================
module dklc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input dklc_pkg::t_draw_res o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // an accepted request keeps the block busy for the scan
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready ##1 !o_in_ready))
        else $error("request taken during scan");

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.hit) |-> !o_out_data.evicted_valid)
        else $error("hit flagged as eviction");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("not idle after reset");

endmodule

bind draw_key_lru_cache_unit dklc_checker u_dklc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for draw_key_lru_cache_unit. Draw request keys go in
// over the request channel, and every result is compared field by field
// against an in-bench lru table model. Directed keys cover the field
// extremes, the ignored index fields of array draws, indexed against array
// kinds and the out-of-range colour code. A table overflow then forces lru
// replacement. Last comes random traffic that mostly revisits recent keys.
// The sender idles in bursts and the receiver stalls in changing patterns.
// ============================================================================
module testbench;

    localparam int N_ENTRIES     = dklc_pkg::CACHE_ENTRIES_DEF;
    localparam int REQ_BITS      = $bits(dklc_pkg::t_draw_req);
    localparam int POOL_DEPTH    = 170;
    localparam int RANDOM_ITEMS  = 570;
    localparam int DRAIN_CYCLES  = 300;
    // the limit is several times the sum of one lookup, the longest sender
    // gap and the longest receiver stall
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_BURSTY} t_rx_mode;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    // dut connections
    logic                in_valid  = 1'b0;
    logic                in_ready;
    dklc_pkg::t_draw_req in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    dklc_pkg::t_draw_res out_data;

    draw_key_lru_cache_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // lru table model state
    bit                  tbl_valid [N_ENTRIES];
    bit [31:0]           tbl_stamp [N_ENTRIES];
    dklc_pkg::t_draw_req tbl_key   [N_ENTRIES];
    bit [31:0]           use_count = '0;

    dklc_pkg::t_draw_res pending_results [$];
    dklc_pkg::t_draw_req key_pool [$];

    int mismatch_count = 0;
    int n_sent         = 0;
    int n_checked      = 0;
    int n_hits         = 0;
    int n_misses       = 0;
    int n_evictions    = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;

    t_rx_mode rx_mode      = RX_ALWAYS;
    int       rx_mode_left = 0;
    int       rx_hold      = 0;

    // stored key form: array draws drop the index fields
    function automatic dklc_pkg::t_draw_req stored_form(input dklc_pkg::t_draw_req req);
        dklc_pkg::t_draw_req k;
        k = req;
        if (req.first_vertex != dklc_pkg::INDEXED_FIRST) begin
            k.vertex_count   = '0;
            k.index_addr     = '0;
            k.index_is_short = 1'b0;
        end
        return k;
    endfunction

    // search, lru choice and table update for one accepted request
    function automatic dklc_pkg::t_draw_res lookup_predict(input dklc_pkg::t_draw_req req);
        dklc_pkg::t_draw_req key;
        dklc_pkg::t_draw_res res;
        int                  pick;
        bit                  found;
        bit                  stop;
        key   = stored_form(req);
        found = 1'b0;
        pick  = 0;
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (!found && tbl_valid[i] && tbl_key[i] == key) begin
                pick  = i;
                found = 1'b1;
            end
        end
        use_count = use_count + 32'd1;
        if (found) begin
            tbl_stamp[pick]   = use_count;
            res.hit           = 1'b1;
            res.slot          = pick[dklc_pkg::SLOT_W-1:0];
            res.evicted_valid = 1'b0;
            n_hits++;
        end else begin
            // first free entry, else lowest stamp with the earliest slot on ties
            stop = 1'b0;
            pick = 0;
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (!stop) begin
                    if (!tbl_valid[i]) begin
                        pick = i;
                        stop = 1'b1;
                    end else if (tbl_stamp[i] < tbl_stamp[pick]) begin
                        pick = i;
                    end
                end
            end
            res.hit           = 1'b0;
            res.slot          = pick[dklc_pkg::SLOT_W-1:0];
            res.evicted_valid = tbl_valid[pick];
            if (tbl_valid[pick]) n_evictions++;
            n_misses++;
            tbl_stamp[pick] = use_count;
            tbl_valid[pick] = 1'b1;
            tbl_key[pick]   = key;
        end
        return res;
    endfunction

    // random field values with the extremes weighted in
    function automatic logic [30:0] rand_u31();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_addr();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic dklc_pkg::t_draw_req rand_key();
        dklc_pkg::t_draw_req k;
        k.first_vertex   = $urandom_range(0, 1) ? dklc_pkg::INDEXED_FIRST
                                                : $signed({1'b0, rand_u31()});
        k.draw_count     = rand_u31();
        k.vertex_count   = rand_u31();
        k.index_addr     = rand_addr();
        k.index_is_short = 1'($urandom_range(0, 1));
        k.position_addr  = rand_addr();
        k.normal_addr    = rand_addr();
        k.color_addr     = rand_addr();
        k.texcoord0_addr = rand_addr();
        k.texcoord1_addr = rand_addr();
        k.enable_mask    = 5'($urandom_range(0, 31));
        k.color_format   = 2'($urandom_range(0, 2));
        return k;
    endfunction

    // one flipped bit anywhere in the key; negative starts become indexed
    function automatic dklc_pkg::t_draw_req near_key(input dklc_pkg::t_draw_req k);
        logic [REQ_BITS-1:0] v;
        dklc_pkg::t_draw_req r;
        v = k;
        v[$urandom_range(0, REQ_BITS - 1)] ^= 1'b1;
        r = dklc_pkg::t_draw_req'(v);
        if (r.first_vertex[31] && r.first_vertex != dklc_pkg::INDEXED_FIRST)
            r.first_vertex = dklc_pkg::INDEXED_FIRST;
        return r;
    endfunction

    // send one request transaction, idling between bursts
    task automatic send_request(input dklc_pkg::t_draw_req req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(lookup_predict(req));
        n_sent++;
        burst_left--;
    endtask

    // field extremes and the key matching corner cases
    task automatic test_directed_keys();
        dklc_pkg::t_draw_req base;
        dklc_pkg::t_draw_req k;
        dklc_pkg::t_draw_req ones;
        base = '0;
        send_request(base);
        send_request(base);
        // array draw: index fields are ignored, so this hits
        k                = base;
        k.vertex_count   = '1;
        k.index_addr     = '1;
        k.index_is_short = 1'b1;
        send_request(k);
        // same fields but indexed: never matches the array entry
        k              = base;
        k.first_vertex = dklc_pkg::INDEXED_FIRST;
        send_request(k);
        ones              = '1;
        ones.color_format = 2'd2;
        send_request(ones);
        send_request(ones);
        k                = ones;
        k.index_is_short = 1'b0;
        send_request(k);
        k              = ones;
        k.first_vertex = 32'sh7FFF_FFFF;
        send_request(k);
        // out-of-range colour code is just another key value
        k              = base;
        k.color_format = 2'd3;
        send_request(k);
        send_request(k);
        k              = base;
        k.color_format = 2'd1;
        send_request(k);
        for (int b = 0; b < 5; b++) begin
            k             = base;
            k.enable_mask = 5'(1 << b);
            send_request(k);
        end
        k                = base;
        k.texcoord1_addr = 64'h8000_0000_0000_0000;
        send_request(k);
        // revisit the indexed twin of the first key
        k              = base;
        k.first_vertex = dklc_pkg::INDEXED_FIRST;
        send_request(k);
    endtask

    // overflow the table so the oldest entries get replaced, then revisit
    task automatic test_table_replacement();
        dklc_pkg::t_draw_req fill_keys [$];
        dklc_pkg::t_draw_req k;
        for (int i = 0; i < N_ENTRIES + 12; i++) begin
            k = rand_key();
            fill_keys.push_back(k);
            send_request(k);
        end
        for (int i = 0; i < 30; i++)
            send_request(fill_keys[$urandom_range(0, fill_keys.size() - 1)]);
    endtask

    // mostly recent keys again, some near misses, kind swaps and fresh keys
    task automatic test_random_traffic(input int n_items);
        dklc_pkg::t_draw_req k;
        int                  pick;
        int                  lim;
        int                  r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (key_pool.size() == 0 || r >= 80) begin
                k = rand_key();
            end else begin
                lim = (key_pool.size() - 1 < 99) ? key_pool.size() - 1 : 99;
                if ($urandom_range(0, 9) < 7)
                    pick = key_pool.size() - 1 - $urandom_range(0, lim);
                else
                    pick = $urandom_range(0, key_pool.size() - 1);
                k = key_pool[pick];
                if (r < 55) begin
                    if (k.first_vertex != dklc_pkg::INDEXED_FIRST && $urandom_range(0, 1)) begin
                        k.vertex_count   = rand_u31();
                        k.index_addr     = rand_addr();
                        k.index_is_short = 1'($urandom_range(0, 1));
                    end
                end else if (r < 72) begin
                    k = near_key(k);
                end else if (k.first_vertex == dklc_pkg::INDEXED_FIRST) begin
                    k.first_vertex = $signed({1'b0, rand_u31()});
                end else begin
                    k.first_vertex = dklc_pkg::INDEXED_FIRST;
                end
            end
            key_pool.push_back(k);
            if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
            send_request(k);
        end
    endtask

    // receiver stall pattern: always ready, random, or long bursty stalls
    always @(posedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(200, 800);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS: begin
                out_ready <= 1'b1;
            end
            RX_RANDOM: begin
                out_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (rx_hold != 0) begin
                    rx_hold <= rx_hold - 1;
                end else begin
                    out_ready <= !out_ready;
                    rx_hold   <= out_ready ? $urandom_range(1, 200) : $urandom_range(0, 3);
                end
            end
        endcase
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk) begin : check_results
        dklc_pkg::t_draw_res want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hit %0b slot %0d evict %0b",
                         $time, out_data.hit, out_data.slot, out_data.evicted_valid);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (out_data.hit !== want.hit) begin
                    $display("%0t: hit mismatch, expected %0b, actual %0b",
                             $time, want.hit, out_data.hit);
                    mismatch_count++;
                end
                if (out_data.slot !== want.slot) begin
                    $display("%0t: slot mismatch, expected %0d, actual %0d",
                             $time, want.slot, out_data.slot);
                    mismatch_count++;
                end
                if (out_data.evicted_valid !== want.evicted_valid) begin
                    $display("%0t: evicted_valid mismatch, expected %0b, actual %0b",
                             $time, want.evicted_valid, out_data.evicted_valid);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, pending_results.size());
                $display("draw_key_lru_cache_unit test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // test sequence
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_keys();
        test_table_replacement();
        test_random_traffic(RANDOM_ITEMS);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d draw requests, %0d results checked, %0d mismatches",
                 n_sent, n_checked, mismatch_count);
        $display("lookups: %0d hits, %0d misses, %0d of them replacing a valid entry",
                 n_hits, n_misses, n_evictions);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("draw_key_lru_cache_unit test passed");
        end else begin
            $display("draw_key_lru_cache_unit test failed");
        end
        $finish;
    end

endmodule
